// File: src/column_min_max_normalizer_top_defines.svh
// Assertion macros used by the column min-max normalizer checker.
`ifndef COLUMN_MIN_MAX_NORMALIZER_TOP_DEFINES_SVH
`define COLUMN_MIN_MAX_NORMALIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CMMN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CMMN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cmmn_pkg.sv
// Package with widths, command codes and control structs of the normalizer.
package cmmn_pkg;

  localparam int CMD_W   = 2;
  localparam int COL_W   = 4;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int NORM_W  = FRAC_W + 1;
  localparam int CNTC_W  = 9;

  localparam logic [CMD_W-1:0] CMD_RANGE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NORMALIZE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

  localparam logic [NORM_W-1:0] ONE_Q16 = NORM_W'(1) << FRAC_W;

  localparam int DIV_STEPS = NORM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic capture;
    logic clear;
    logic write_range;
    logic eval;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             need_div;
    logic             div_busy;
    logic             out_stall;
  } ctrl_status_t;

endpackage

// File: src/cmmn_if.sv
// Input and output channel interfaces of the normalizer.
interface cmmn_in_if;
  logic                              valid;
  logic                              ready;
  logic [cmmn_pkg::CMD_W-1:0]        cmd;
  logic [cmmn_pkg::COL_W-1:0]        column;
  logic signed [cmmn_pkg::VAL_W-1:0] sample_value;

  modport source (output valid, cmd, column, sample_value, input ready);
  modport sink (input valid, cmd, column, sample_value, output ready);
endinterface

interface cmmn_out_if;
  logic                        valid;
  logic                        ready;
  logic [cmmn_pkg::COL_W-1:0]  out_column;
  logic [cmmn_pkg::NORM_W-1:0] norm_value;
  logic                        out_of_range;
  logic                        zero_span;

  modport source (output valid, out_column, norm_value, out_of_range, zero_span, input ready);
  modport sink (input valid, out_column, norm_value, out_of_range, zero_span, output ready);
endinterface

// File: src/column_min_max_normalizer_top.sv
// Top level of the per-column min-max normalizer.
// Input channel in_ch carries cmd, column and a signed Q16.16 sample_value.
// cmd 0 folds the sample into its column's running min and max, cmd 1
// normalizes the sample to an unsigned 1.16 fraction, cmd 2 clears all
// column ranges; cmd 3 is dropped. Only cmd 1 yields a transaction on
// out_ch: out_column, norm_value (65536 is 1.0), out_of_range, zero_span.
// One transaction is in work at a time; in_ch.ready is high only when idle.
// Range update steps: accept, store read, write back. Clear: accept, then
// the seen marks are cleared in the read state. Normalize with a span to
// divide by: accept, store read, evaluate and start the 17-step radix-2
// divider (one quotient bit a cycle), wait while it is busy, then load the
// result; saturated or zero-span results skip the divider.
// The result sits in an output register; range and clear transactions keep
// flowing while it waits, and a normalize holds only until out_ch.ready.
// Reset (rst, synchronous) clears all column seen marks and empties the
// output register; the min and max stores are not cleared.
// MAX_COLUMNS sets the store depth; a column at or beyond it is unseen.
module column_min_max_normalizer_top #(
  parameter int MAX_COLUMNS = 16
) (
  input  logic              clk,
  input  logic              rst,
  cmmn_in_if.sink           in_ch,
  cmmn_out_if.source        out_ch
);

  cmmn_pkg::ctrl_cmd_t    cmd;
  cmmn_pkg::ctrl_status_t status;

  cmmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cmmn_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_cmd       (in_ch.cmd),
    .in_column    (in_ch.column),
    .in_value     (in_ch.sample_value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_column   (out_ch.out_column),
    .norm_value   (out_ch.norm_value),
    .out_of_range (out_ch.out_of_range),
    .zero_span    (out_ch.zero_span)
  );

endmodule

// File: src/cmmn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmmn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/cmmn_div.sv
// Radix-2 restoring divider producing the 17-bit fraction quotient.
module cmmn_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cmmn_pkg::VAL_W-1:0]  num,
  input  logic [cmmn_pkg::VAL_W-1:0]  span,
  output logic                        busy,
  output logic [cmmn_pkg::NORM_W-1:0] quo
);

  logic [cmmn_pkg::DIV_CNT_W-1:0] cnt;
  logic [cmmn_pkg::VAL_W-1:0]     rem;
  logic [cmmn_pkg::NORM_W-1:0]    dbits;
  logic [cmmn_pkg::VAL_W:0]       trial;
  logic [cmmn_pkg::VAL_W:0]       diff;

  assign trial = {rem, dbits[cmmn_pkg::NORM_W-1]};
  assign diff  = trial - {1'b0, span};
  assign busy  = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= cmmn_pkg::DIV_CNT_W'(cmmn_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num[cmmn_pkg::VAL_W-1:1]};
      dbits <= {num[0], {cmmn_pkg::FRAC_W{1'b0}}};
      quo   <= '0;
    end else if (busy) begin
      if (!diff[cmmn_pkg::VAL_W]) begin
        rem <= diff[cmmn_pkg::VAL_W-1:0];
        quo <= {quo[cmmn_pkg::NORM_W-2:0], 1'b1};
      end else begin
        rem <= trial[cmmn_pkg::VAL_W-1:0];
        quo <= {quo[cmmn_pkg::NORM_W-2:0], 1'b0};
      end
      dbits <= {dbits[cmmn_pkg::NORM_W-2:0], 1'b0};
    end
  end

endmodule

// File: src/cmmn_ctrl.sv
// Controller state machine sequencing capture, range update, clear and normalize.
module cmmn_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cmmn_pkg::ctrl_status_t status,
  output cmmn_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        case (status.cmd)
          cmmn_pkg::CMD_RANGE:     state_next = S_EVAL;
          cmmn_pkg::CMD_NORMALIZE: state_next = S_EVAL;
          cmmn_pkg::CMD_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_EVAL: begin
        if (status.cmd == cmmn_pkg::CMD_RANGE) begin
          cmd.write_range = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.eval = 1'b1;
          if (status.need_div) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/cmmn_dp.sv
// Datapath: column range stores, seen marks, range compare, divider, result register.
module cmmn_dp #(
  parameter int MAX_COLUMNS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cmmn_pkg::ctrl_cmd_t                cmd,
  output cmmn_pkg::ctrl_status_t             status,
  input  logic [cmmn_pkg::CMD_W-1:0]         in_cmd,
  input  logic [cmmn_pkg::COL_W-1:0]         in_column,
  input  logic signed [cmmn_pkg::VAL_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cmmn_pkg::COL_W-1:0]         out_column,
  output logic [cmmn_pkg::NORM_W-1:0]        norm_value,
  output logic                               out_of_range,
  output logic                               zero_span
);

  localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [cmmn_pkg::CMD_W-1:0]        c_cmd;
  logic [cmmn_pkg::COL_W-1:0]        c_col;
  logic signed [cmmn_pkg::VAL_W-1:0] c_val;

  logic [IDX_W+cmmn_pkg::COL_W-1:0]  col_ext;
  logic [IDX_W-1:0]                  addr;
  logic                              valid_col;
  logic                              seen_hit;
  logic [MAX_COLUMNS-1:0]            seen;

  logic signed [cmmn_pkg::VAL_W-1:0] mx;
  logic signed [cmmn_pkg::VAL_W-1:0] mn;
  logic [cmmn_pkg::VAL_W-1:0]        new_max;
  logic [cmmn_pkg::VAL_W-1:0]        new_min;
  logic                              ram_we;

  logic [cmmn_pkg::VAL_W:0]          num_ext;
  logic [cmmn_pkg::VAL_W:0]          span_ext;
  logic [cmmn_pkg::NORM_W-1:0]       quo;
  logic                              div_busy;

  logic [cmmn_pkg::NORM_W-1:0]       e_norm;
  logic                              e_oor;
  logic                              e_zspan;
  logic                              e_div;

  logic [cmmn_pkg::NORM_W-1:0]       res_norm;
  logic                              res_oor;
  logic                              res_zspan;
  logic                              res_div;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_cmd <= in_cmd;
      c_col <= in_column;
      c_val <= in_value;
    end
  end

  assign col_ext   = {{IDX_W{1'b0}}, c_col};
  assign addr      = col_ext[IDX_W-1:0];
  assign valid_col = ({{(cmmn_pkg::CNTC_W - cmmn_pkg::COL_W){1'b0}}, c_col}
                     < cmmn_pkg::CNTC_W'(MAX_COLUMNS));
  assign seen_hit  = valid_col && seen[addr];

  assign new_max = (!seen_hit || (c_val > mx)) ? c_val : mx;
  assign new_min = (!seen_hit || (c_val < mn)) ? c_val : mn;
  assign ram_we  = cmd.write_range && valid_col;

  cmmn_ram #(
    .WIDTH (cmmn_pkg::VAL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_max_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (new_max),
    .raddr (addr),
    .rdata (mx)
  );

  cmmn_ram #(
    .WIDTH (cmmn_pkg::VAL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_min_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (new_min),
    .raddr (addr),
    .rdata (mn)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      seen <= '0;
    end else if (ram_we) begin
      seen[addr] <= 1'b1;
    end
  end

  always_comb begin
    e_norm  = '0;
    e_oor   = 1'b0;
    e_zspan = 1'b0;
    e_div   = 1'b0;
    if (!seen_hit || (mx <= mn)) begin
      e_zspan = 1'b1;
    end else if (c_val < mn) begin
      e_oor = 1'b1;
    end else if (c_val > mx) begin
      e_norm = cmmn_pkg::ONE_Q16;
      e_oor  = 1'b1;
    end else begin
      e_div = 1'b1;
    end
  end

  assign num_ext  = {c_val[cmmn_pkg::VAL_W-1], c_val} - {mn[cmmn_pkg::VAL_W-1], mn};
  assign span_ext = {mx[cmmn_pkg::VAL_W-1], mx} - {mn[cmmn_pkg::VAL_W-1], mn};

  cmmn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_ext[cmmn_pkg::VAL_W-1:0]),
    .span  (span_ext[cmmn_pkg::VAL_W-1:0]),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_norm  <= e_norm;
      res_oor   <= e_oor;
      res_zspan <= e_zspan;
      res_div   <= e_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_column   <= c_col;
      norm_value   <= res_div ? quo : res_norm;
      out_of_range <= res_oor;
      zero_span    <= res_zspan;
    end
  end

  assign status.cmd       = c_cmd;
  assign status.need_div  = e_div;
  assign status.div_busy  = div_busy;
  assign status.out_stall = out_valid && !out_ready;

endmodule

// File: src/cmmn_checker.sv
// Port-level checker for the normalizer and its bind to the top level.
`include "column_min_max_normalizer_top_defines.svh"

module cmmn_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmmn_pkg::NORM_W-1:0] norm_value,
  input logic                        out_of_range,
  input logic                        zero_span
);

  `CMMN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CMMN_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "accepted a transaction while busy")
  `CMMN_ASSERT_NOW(a_zero_span, clk, rst, out_valid && zero_span, (norm_value == '0) && !out_of_range, "zero span result not zero")
  `CMMN_ASSERT_NOW(a_saturate, clk, rst, out_valid && out_of_range, (norm_value == '0) || (norm_value == cmmn_pkg::ONE_Q16), "out of range result not saturated")
  `CMMN_ASSERT_NOW(a_norm_max, clk, rst, out_valid, norm_value <= cmmn_pkg::ONE_Q16, "fraction above one")

endmodule

bind column_min_max_normalizer_top cmmn_checker u_cmmn_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .norm_value   (out_ch.norm_value),
  .out_of_range (out_ch.out_of_range),
  .zero_span    (out_ch.zero_span)
);
